FILE: hdl/crc16_bit_frame_checker_top_assert.svh
// Assertion helpers for the checker datapath RTL.
// Every macro expects signals named clk and rst in scope.
`ifndef CRC16_BIT_FRAME_CHECKER_TOP_ASSERT_SVH
`define CRC16_BIT_FRAME_CHECKER_TOP_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define CRCCHK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define CRCCHK_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CRCCHK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/crcchk_pkg.sv
package crcchk_pkg;

  localparam int MAX_PAYLOAD = 4096;
  localparam int LEN_W       = 13;
  localparam int CRC_W       = 16;
  localparam int CRC_LEN     = 16;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [CRC_W-1:0] CRC_POLY      = 16'h1021;
  localparam logic [LEN_W-1:0] PAYLOAD_RESET = 13'd128;
  localparam logic [LEN_W-1:0] LEN_MAX       = LEN_W'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0] LEN_MIN       = 13'd1;
  localparam logic [LEN_W-1:0] CRC_LEN_L     = LEN_W'(CRC_LEN);

  // register indexes (word address)
  localparam logic REG_PAYLOAD_BITS = 1'b0;

  // frame configuration handed from the register block to the datapath
  typedef struct packed {
    logic [LEN_W-1:0] payload_len; // clamped to 1..MAX_PAYLOAD
    logic             restart;     // register write: restart the frame
  } cfg_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] n;
    n = raw;
    if (n < LEN_MIN) begin
      n = LEN_MIN;
    end
    if (n > LEN_MAX) begin
      n = LEN_MAX;
    end
    return n;
  endfunction

endpackage

FILE: hdl/crcchk_if.sv
// Input channel: one received bit per request.
interface crcchk_in_if;
  logic valid;
  logic ready;
  logic data_bit;

  modport source (output valid, output data_bit, input ready);
  modport sink   (input valid, input data_bit, output ready);
endinterface

// Result channel: payload bit or end-of-frame status.
interface crcchk_out_if;
  logic valid;
  logic ready;
  logic out_bit;
  logic is_status;
  logic first_of_frame;
  logic crc_fail;

  modport source (output valid, output out_bit, output is_status,
                  output first_of_frame, output crc_fail, input ready);
  modport sink   (input valid, input out_bit, input is_status,
                  input first_of_frame, input crc_fail, output ready);
endinterface

FILE: hdl/crcchk_regs.sv
module crcchk_regs
  import crcchk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [LEN_W-1:0] payload_bits;
  logic [LEN_W-1:0] payload_len;
  logic             wr_len;

  assign pready = 1'b1;
  assign wr_len = psel && penable && pwrite && (paddr[APB_AW-1] == REG_PAYLOAD_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bits <= PAYLOAD_RESET;
      payload_len  <= PAYLOAD_RESET;
    end else if (wr_len) begin
      payload_bits <= pwdata[LEN_W-1:0];
      payload_len  <= clamp_len(pwdata[LEN_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1] == REG_PAYLOAD_BITS) begin
      prdata = {{(APB_DW-LEN_W){1'b0}}, payload_bits};
    end
  end

  assign cfg.payload_len = payload_len;
  assign cfg.restart     = wr_len;

endmodule

FILE: hdl/crcchk_datapath.sv
module crcchk_datapath
  import crcchk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  crcchk_in_if.sink    bit_in,
  crcchk_out_if.source res_out
);

  // input register
  logic             s1_valid;
  logic             s1_bit;
  // frame state
  logic [CRC_W-1:0] crc_shift;
  logic [LEN_W-1:0] bit_position;
  // result register
  logic             o_valid;
  logic             o_bit;
  logic             o_status;
  logic             o_first;
  logic             o_error;

  logic [LEN_W-1:0] pos_eff;
  logic             in_payload;
  logic             last_bit;
  logic             has_result;
  logic             fb;
  logic [CRC_W-1:0] crc_step;
  logic             s1_fire;

  always_comb begin
    pos_eff = bit_position;
    if (bit_position >= cfg.payload_len + CRC_LEN_L) begin
      pos_eff = '0;
    end
  end

  assign in_payload = pos_eff < cfg.payload_len;
  assign last_bit   = !in_payload && (pos_eff == cfg.payload_len + CRC_LEN_L - LEN_W'(1));
  assign has_result = in_payload || last_bit;

  // CRC bits enter inverted
  assign fb       = s1_bit ^ crc_shift[CRC_W-1] ^ !in_payload;
  assign crc_step = {crc_shift[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);

  // items without a result never wait on the output side
  assign s1_fire      = s1_valid && (!has_result || !o_valid || res_out.ready);
  assign bit_in.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bit_in.ready) begin
      s1_valid <= bit_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bit_in.ready && bit_in.valid) begin
      s1_bit <= bit_in.data_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      crc_shift    <= '0;
      bit_position <= '0;
    end else if (s1_fire) begin
      if (last_bit) begin
        crc_shift    <= '0;
        bit_position <= '0;
      end else begin
        crc_shift    <= crc_step;
        bit_position <= pos_eff + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_fire && has_result) begin
      o_valid <= 1'b1;
    end else if (res_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      o_bit    <= in_payload ? s1_bit : 1'b0;
      o_status <= last_bit;
      o_first  <= in_payload && (pos_eff == '0);
      o_error  <= last_bit && (crc_step != '0);
    end
  end

  assign res_out.valid          = o_valid;
  assign res_out.out_bit        = o_bit;
  assign res_out.is_status      = o_status;
  assign res_out.first_of_frame = o_first;
  assign res_out.crc_fail       = o_error;

`include "crc16_bit_frame_checker_top_assert.svh"

  `CRCCHK_ASSERT_ALWAYS(a_pos_in_frame, bit_position < cfg.payload_len + CRC_LEN_L,
                        "bit position past frame end")
  `CRCCHK_ASSERT_NEXT(a_status_restarts, s1_fire && last_bit && !cfg.restart,
                      (crc_shift == '0) && (bit_position == '0),
                      "frame state not cleared after status")
  `CRCCHK_ASSERT_NEXT(a_cfg_restarts, cfg.restart,
                      (crc_shift == '0) && (bit_position == '0),
                      "config write did not restart frame")
  `CRCCHK_ASSERT_IMPLIES(a_status_fields, o_valid && o_status, !o_bit && !o_first,
                         "status result carries payload fields")

endmodule

FILE: hdl/crc16_bit_frame_checker_top.sv
// Serial CRC-16 frame checker (poly 0x1021, init 0). Takes one bit per
// request; a frame is payload_bits payload bits followed by 16 CRC bits.
// Each payload bit comes back out as a result; the CRC bits give nothing
// except the last, which returns a status result with crc_fail set for a
// nonzero remainder. Throughput is one bit per clock unless a result
// stalls; the input register feeds the LFSR and the result register.
// Results that wait on res_out.ready do not stop CRC bits from draining.
// Writing payload_bits (byte address 0, values 0 and >4096 are clamped
// to 1 and 4096) restarts the frame; write only while the block is idle.
module crc16_bit_frame_checker_top
  import crcchk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input bits
  crcchk_in_if.sink         bit_in,
  // results
  crcchk_out_if.source      res_out,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  // payload_bits register, clamped length and restart strobe
  crcchk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register -> LFSR and bit counter -> result register
  crcchk_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .bit_in  (bit_in),
    .res_out (res_out)
  );

endmodule
